FILE: rtl/assert_macros.svh
// Assertion macros used by the quaternion_to_yaw top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent holds
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Check that an expression holds at every clock edge out of reset
`define ASSERT_HOLD(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`endif

FILE: rtl/qty_pkg.sv
// Shared types, constants and the arctangent table for the yaw block
package qty_pkg;

    // Number of CORDIC micro-rotations (8 to 24)
    localparam int ITERATIONS = 16;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    // Datapath widths
    localparam int QW   = 16;  // quaternion component
    localparam int PW   = 32;  // component product
    localparam int SW   = 34;  // s and c at scale 2^-30
    localparam int VW   = 36;  // CORDIC vector with gain headroom
    localparam int AW   = 34;  // angle accumulator, Q.30 radians
    localparam int HW   = 16;  // heading, Q2.13

    // Cycles from an accepted transaction to its strobe
    localparam int LATENCY = ITERATIONS + 5;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = AW'(64'sd1686629713);
    localparam logic signed [SW-1:0] ONE_Q30     = SW'(64'sd1073741824);
    localparam logic signed [HW-1:0] HEAD_MAX    = HW'(25736);

    // Quadrant pre-rotation applied by the front
    typedef enum logic [1:0] {
        QUAD_RIGHT,
        QUAD_UPPER,
        QUAD_LOWER
    } quad_t;

    // One queue entry: pre-rotated vector, its quadrant and the zero flag
    typedef struct packed {
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        quad_t                quad;
        logic                 zero;
    } entry_t;

    // atan(2^-i) in Q.30 radians, rounded to nearest
    function automatic logic [AW-1:0] atan_q30(input int idx);
        logic [AW-1:0] val;
        begin
            case (idx)
                0:       val = AW'(843314857);
                1:       val = AW'(497837829);
                2:       val = AW'(263043837);
                3:       val = AW'(133525159);
                4:       val = AW'(67021687);
                5:       val = AW'(33543516);
                6:       val = AW'(16775851);
                7:       val = AW'(8388437);
                8:       val = AW'(4194283);
                9:       val = AW'(2097149);
                10:      val = AW'(1048576);
                11:      val = AW'(524288);
                12:      val = AW'(262144);
                13:      val = AW'(131072);
                14:      val = AW'(65536);
                15:      val = AW'(32768);
                16:      val = AW'(16384);
                17:      val = AW'(8192);
                18:      val = AW'(4096);
                19:      val = AW'(2048);
                20:      val = AW'(1024);
                21:      val = AW'(512);
                22:      val = AW'(256);
                23:      val = AW'(128);
                24:      val = AW'(64);
                25:      val = AW'(32);
                26:      val = AW'(16);
                27:      val = AW'(8);
                28:      val = AW'(4);
                29:      val = AW'(2);
                30:      val = AW'(1);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

FILE: rtl/qty_front.sv
// Front end: forms s and c from the quaternion and pre-rotates into the right half-plane
module qty_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [qty_pkg::QW-1:0]  quat_w,
    input  logic signed [qty_pkg::QW-1:0]  quat_x,
    input  logic signed [qty_pkg::QW-1:0]  quat_y,
    input  logic signed [qty_pkg::QW-1:0]  quat_z,
    output logic                           push,
    output qty_pkg::entry_t                push_entry,
    output logic [1:0]                     fill
);

    logic                          prod_valid_reg;
    logic signed [qty_pkg::PW-1:0] wz_reg;
    logic signed [qty_pkg::PW-1:0] xy_reg;
    logic signed [qty_pkg::PW-1:0] yy_reg;
    logic signed [qty_pkg::PW-1:0] zz_reg;

    logic                          sc_valid_reg;
    logic signed [qty_pkg::SW-1:0] s_reg;
    logic signed [qty_pkg::SW-1:0] c_reg;
    logic signed [qty_pkg::SW-1:0] s_next;
    logic signed [qty_pkg::SW-1:0] c_next;

    logic signed [qty_pkg::VW-1:0] s_ext;
    logic signed [qty_pkg::VW-1:0] c_ext;

    // Advance the valid marks of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sc_valid_reg   <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sc_valid_reg   <= prod_valid_reg;
        end
    end

    // Register the four component products
    always_ff @(posedge clk)
    begin
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
    end

    // Form s = 2(wz + xy) and c = 1 - 2(yy + zz) at scale 2^-30
    always_comb
    begin
        s_next = (qty_pkg::SW'(wz_reg) + qty_pkg::SW'(xy_reg)) <<< 1;
        c_next = qty_pkg::ONE_Q30 - ((qty_pkg::SW'(yy_reg) + qty_pkg::SW'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        c_reg <= c_next;
    end

    // Classify the quadrant and rotate by a quarter turn where c is negative
    always_comb
    begin
        s_ext           = qty_pkg::VW'(s_reg);
        c_ext           = qty_pkg::VW'(c_reg);
        push_entry.zero = (s_reg == '0) && (c_reg == '0);
        if (!c_reg[qty_pkg::SW-1])
        begin
            push_entry.vx   = c_ext;
            push_entry.vy   = s_ext;
            push_entry.quad = qty_pkg::QUAD_RIGHT;
        end
        else if (!s_reg[qty_pkg::SW-1])
        begin
            push_entry.vx   = s_ext;
            push_entry.vy   = -c_ext;
            push_entry.quad = qty_pkg::QUAD_UPPER;
        end
        else
        begin
            push_entry.vx   = -s_ext;
            push_entry.vy   = c_ext;
            push_entry.quad = qty_pkg::QUAD_LOWER;
        end
    end

    assign push = sc_valid_reg;
    assign fill = {1'b0, prod_valid_reg} + {1'b0, sc_valid_reg};

endmodule

FILE: rtl/qty_queue.sv
// Short queue of pre-rotated vectors between front and back
module qty_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  qty_pkg::entry_t              push_entry,
    output logic                         pop,
    output qty_pkg::entry_t              pop_entry,
    output logic [qty_pkg::QCW-1:0]      count
);

    qty_pkg::entry_t             slot_reg [qty_pkg::QDEPTH];
    logic [qty_pkg::QAW-1:0]     wr_ptr_reg;
    logic [qty_pkg::QAW-1:0]     rd_ptr_reg;
    logic [qty_pkg::QCW-1:0]     count_reg;
    logic [qty_pkg::QCW-1:0]     count_next;

    // Drain one entry every cycle the queue holds one
    assign pop       = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Write the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/qty_cordic.sv
// Back end: pipelined CORDIC vectoring, rounding and saturation of the heading
module qty_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  qty_pkg::entry_t               in_entry,
    output logic                          done,
    output logic signed [qty_pkg::HW-1:0] heading
);

    localparam int N  = qty_pkg::ITERATIONS;
    localparam int RW = qty_pkg::AW - 17;

    logic [N:0]                    valid_reg;
    logic [N:0]                    zero_reg;
    logic signed [qty_pkg::VW-1:0] vx_reg  [0:N];
    logic signed [qty_pkg::VW-1:0] vy_reg  [0:N];
    logic signed [qty_pkg::AW-1:0] ang_reg [0:N];
    logic signed [qty_pkg::AW-1:0] ang_next;

    logic signed [qty_pkg::AW-1:0] rnd;
    logic signed [RW-1:0]          r_q13;
    logic signed [qty_pkg::HW-1:0] heading_next;
    logic signed [qty_pkg::HW-1:0] heading_reg;
    logic                          done_reg;

    // Seed the angle from the quadrant pre-rotation
    always_comb
    begin
        case (in_entry.quad)
            qty_pkg::QUAD_RIGHT: ang_next = '0;
            qty_pkg::QUAD_UPPER: ang_next = qty_pkg::HALF_PI_Q30;
            qty_pkg::QUAD_LOWER: ang_next = -qty_pkg::HALF_PI_Q30;
            default:             ang_next = '0;
        endcase
    end

    // Load the entry popped from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg[0]   <= in_entry.vx;
        vy_reg[0]   <= in_entry.vy;
        ang_reg[0]  <= ang_next;
        zero_reg[0] <= in_entry.zero;
    end

    // One micro-rotation per stage, steering the vector towards the x axis
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [qty_pkg::VW-1:0] dx;
        logic signed [qty_pkg::VW-1:0] dy;
        logic signed [qty_pkg::AW-1:0] step;

        assign dx   = vy_reg[i] >>> i;
        assign dy   = vx_reg[i] >>> i;
        assign step = qty_pkg::atan_q30(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (!vy_reg[i][qty_pkg::VW-1])
            begin
                vx_reg[i+1]  <= vx_reg[i] + dx;
                vy_reg[i+1]  <= vy_reg[i] - dy;
                ang_reg[i+1] <= ang_reg[i] + step;
            end
            else
            begin
                vx_reg[i+1]  <= vx_reg[i] - dx;
                vy_reg[i+1]  <= vy_reg[i] + dy;
                ang_reg[i+1] <= ang_reg[i] - step;
            end
        end
    end

    // Round Q.30 to Q2.13 with ties upwards, then clamp to plus or minus pi
    always_comb
    begin
        rnd   = ang_reg[N] + qty_pkg::AW'(65536);
        r_q13 = rnd[qty_pkg::AW-1:17];
        if (zero_reg[N])
        begin
            heading_next = '0;
        end
        else if (r_q13 > RW'(qty_pkg::HEAD_MAX))
        begin
            heading_next = qty_pkg::HEAD_MAX;
        end
        else if (r_q13 < -RW'(qty_pkg::HEAD_MAX))
        begin
            heading_next = -qty_pkg::HEAD_MAX;
        end
        else
        begin
            heading_next = r_q13[qty_pkg::HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign done    = done_reg;
    assign heading = heading_reg;

endmodule

FILE: rtl/quaternion_to_yaw.sv
// Top level of the quaternion yaw block: front end, queue and CORDIC back end
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------
//  command  | start / busy     | quat_w, quat_x, quat_y, quat_z (Q1.15)
//  result   | done (strobe)    | heading (Q2.13 radians)
//
// One transaction is taken per cycle while busy is low; it passes 2 front stages,
// the queue slot and ITERATIONS + 2 back stages before its done strobe.
// busy is high in reset and until the first clock edge after it, and
// otherwise only when the front stages and queue together hold QDEPTH transactions.
// The back end never stalls, so busy stays low under a steady stream.
`include "assert_macros.svh"

module quaternion_to_yaw (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [qty_pkg::QW-1:0] quat_w,
    input  logic signed [qty_pkg::QW-1:0] quat_x,
    input  logic signed [qty_pkg::QW-1:0] quat_y,
    input  logic signed [qty_pkg::QW-1:0] quat_z,
    output logic                          done,
    output logic signed [qty_pkg::HW-1:0] heading
);

    logic                      accept;
    logic                      init_reg;
    logic                      q_push;
    qty_pkg::entry_t           q_push_entry;
    logic                      q_pop;
    qty_pkg::entry_t           q_pop_entry;
    logic [qty_pkg::QCW-1:0]   q_count;
    logic [1:0]                front_fill;
    logic [qty_pkg::QCW-1:0]   occupancy;

    // Hold off commands until out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b0;
        end
        else
        begin
            init_reg <= 1'b1;
        end
    end

    // Refuse a transaction when the queue could not absorb everything in flight
    assign occupancy = qty_pkg::QCW'(front_fill) + q_count;
    assign busy      = !init_reg || (occupancy >= qty_pkg::QCW'(qty_pkg::QDEPTH));
    assign accept    = start && !busy;

    qty_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .push       (q_push),
        .push_entry (q_push_entry),
        .fill       (front_fill)
    );

    qty_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .count      (q_count)
    );

    qty_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_pop),
        .in_entry   (q_pop_entry),
        .done       (done),
        .heading    (heading)
    );

    // Every strobe belongs to a transaction accepted earlier by qty_pkg::LATENCY
    `ASSERT_IMPLY(a_done_latency, done, $past(accept, qty_pkg::LATENCY))
    // The queue is never written when full
    `ASSERT_IMPLY(a_queue_room, q_push, q_count < qty_pkg::QCW'(qty_pkg::QDEPTH))
    // The heading stays within plus or minus pi
    `ASSERT_IMPLY(a_heading_range, done, (heading <= qty_pkg::HEAD_MAX) && (heading >= -qty_pkg::HEAD_MAX))

endmodule

FILE: bench/tb_quaternion_to_yaw.sv
`timescale 1ns / 100ps
// Self-checking testbench for the quaternion to yaw heading block
module tb_quaternion_to_yaw;

    localparam int  QW         = qty_pkg::QW;
    localparam int  HW         = qty_pkg::HW;
    localparam int  ROTATIONS  = (qty_pkg::ITERATIONS > 32) ? 32 : qty_pkg::ITERATIONS;
    localparam int  TAIL       = 2 * qty_pkg::LATENCY + 8;
    localparam int  RANDOM_CNT = 1000;
    localparam int  CYCLE_CAP  = 200000;

    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint HEADING_LIMIT    = 64'sd25736;

    // One quaternion transaction
    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } quat_sample_t;

    // atan(2^-i) in Q.30 radians
    longint atan_rad_q30 [32] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687,  33543516,  16775851,  8388437,
        4194283,   2097149,   1048576,   524288,
        262144,    131072,    65536,     32768,
        16384,     8192,      4096,      2048,
        1024,      512,       256,       128,
        64,        32,        16,        8,
        4,         2,         1,         0
    };

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic signed [QW-1:0] quat_w  = '0;
    logic signed [QW-1:0] quat_x  = '0;
    logic signed [QW-1:0] quat_y  = '0;
    logic signed [QW-1:0] quat_z  = '0;
    logic                 busy;
    logic                 done;
    logic signed [HW-1:0] heading;

    quat_sample_t         quat_pending [$];
    logic signed [HW-1:0] heading_expected [$];
    quat_sample_t         quat_in_flight;
    int                   accepted_count = 0;
    int                   total_quats    = 0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    quaternion_to_yaw dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .done    (done),
        .heading (heading)
    );

    always #5 clk = ~clk;

    // Work out the heading: form s and c, pre-rotate by quadrant, then vector
    function automatic logic signed [HW-1:0] predict_heading(input quat_sample_t q);
        longint w, x, y, z, s, c, vx, vy, ang, dx, dy, r;
        begin
            w = longint'(q.w);
            x = longint'(q.x);
            y = longint'(q.y);
            z = longint'(q.z);
            s = 2 * (w * z + x * y);
            c = (longint'(1) <<< 30) - 2 * (y * y + z * z);
            if (s == 0 && c == 0)
                return '0;
            if (c >= 0) begin
                vx = c;  vy = s;  ang = 0;
            end
            else if (s >= 0) begin
                // Vector on the negative c axis counts as upper half
                vx = s;  vy = -c; ang = QUARTER_TURN_Q30;
            end
            else begin
                vx = -s; vy = c;  ang = -QUARTER_TURN_Q30;
            end
            for (int i = 0; i < ROTATIONS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx = vx + dx; vy = vy - dy; ang = ang + atan_rad_q30[i];
                end
                else begin
                    vx = vx - dx; vy = vy + dy; ang = ang - atan_rad_q30[i];
                end
            end
            // Round half up to Q2.13, then clamp to plus or minus pi
            r = (ang + (longint'(1) <<< 16)) >>> 17;
            if (r > HEADING_LIMIT)
                r = HEADING_LIMIT;
            if (r < -HEADING_LIMIT)
                r = -HEADING_LIMIT;
            return r[HW-1:0];
        end
    endfunction

    // Sender gap in percent for the current stretch of the run
    function automatic int gap_percent(input int sent);
        begin
            if (sent < 270)
                return 0;
            else if (sent < 530)
                return 58;
            else if (sent < 790)
                return 0;
            else
                return 13;
        end
    endfunction

    function automatic logic signed [QW-1:0] pick_edge_value();
        begin
            case ($urandom_range(4))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return -16'sd1;
                3:       return 16'sd1;
                default: return '0;
            endcase
        end
    endfunction

    task automatic queue_quat(input int w, input int x, input int y, input int z);
        quat_sample_t q;
        begin
            q.w = QW'(w);
            q.x = QW'(x);
            q.y = QW'(y);
            q.z = QW'(z);
            quat_pending.push_back(q);
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
            mismatch_count++;
        end
    endtask

    // Driver: record accepted transactions, then launch, hold or drop start
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                heading_expected.push_back(predict_heading(quat_in_flight));
                accepted_count++;
            end
            if (!start || !busy) begin
                if (quat_pending.size() != 0 &&
                    $urandom_range(99) >= gap_percent(accepted_count)) begin
                    quat_in_flight = quat_pending.pop_front();
                    start  <= 1'b1;
                    quat_w <= quat_in_flight.w;
                    quat_x <= quat_in_flight.x;
                    quat_y <= quat_in_flight.y;
                    quat_z <= quat_in_flight.z;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed heading with the oldest prediction
    always @(posedge clk) begin
        logic signed [HW-1:0] want;
        if (rst_n && done === 1'b1) begin
            if (heading_expected.size() == 0) begin
                report_mismatch($sformatf("heading %0d with nothing outstanding", heading));
            end
            else begin
                want = heading_expected.pop_front();
                if (heading !== want)
                    report_mismatch($sformatf("heading got %0d want %0d", heading, want));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int kind, k, w;
        // Directed: extremes, quadrant edges and the degenerate vector
        queue_quat(0, 0, 0, 0);
        queue_quat(32767, 0, 0, 0);
        queue_quat(32767, 32767, 32767, 32767);
        queue_quat(-32768, -32768, -32768, -32768);
        queue_quat(-1, -1, -1, -1);
        queue_quat(23170, 0, 0, 23170);
        queue_quat(23170, 0, 0, -23170);
        queue_quat(0, 0, 0, 32767);
        queue_quat(0, 0, 0, -32768);
        queue_quat(0, 0, -32768, -32768);
        queue_quat(0, 0, 16384, 16384);
        queue_quat(0, 0, -16384, 16384);
        queue_quat(32767, -32768, 16384, 16384);
        queue_quat(-32768, 32767, 16384, 16384);
        queue_quat(-32768, 32767, -32768, 32767);
        queue_quat(0, 32767, 32767, 0);
        queue_quat(0, 32767, -32768, 0);
        queue_quat(1, 0, 0, -1);
        queue_quat(-1, 0, 0, 1);

        // Random: raw patterns, pure yaw, edge values and zero-vector pairs
        for (int n = 0; n < RANDOM_CNT; n++) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                queue_quat(QW'($urandom()), QW'($urandom()), QW'($urandom()), QW'($urandom()));
            end
            else if (kind <= 6) begin
                queue_quat(QW'($urandom()), QW'($urandom_range(7)) - 4,
                           QW'($urandom_range(7)) - 4, QW'($urandom()));
            end
            else if (kind == 7) begin
                queue_quat(pick_edge_value(), pick_edge_value(),
                           pick_edge_value(), pick_edge_value());
            end
            else begin
                // y = z = +-16384 makes c zero; w = -x makes s zero
                k = $urandom_range(1) ? 16384 : -16384;
                w = $signed(QW'($urandom()));
                if (w == -32768)
                    w = 0;
                queue_quat(w, $urandom_range(3) == 0 ? w + 1 : -w, k, k);
            end
        end
        total_quats = quat_pending.size();

        // Hold reset, then release it once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every transaction, then every heading, then a tail
        while (accepted_count != total_quats)
            @(posedge clk);
        while (heading_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (heading_expected.size() != 0)
            report_mismatch($sformatf("%0d headings never arrived", heading_expected.size()));

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/qty_pkg.sv
rtl/qty_front.sv
rtl/qty_queue.sv
rtl/qty_cordic.sv
rtl/quaternion_to_yaw.sv
bench/tb_quaternion_to_yaw.sv
